>>> hw/rtl/rv32i_dec_pkg.sv
// Shared types and constants for the RV32I instruction decoder.
// Holds the major opcodes, format and operation codes, and the decoded result record.
// No dependencies.
package rv32i_dec_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned RegWidth   = 5;
  localparam int unsigned ImmWidth   = 32;
  localparam int unsigned TdataWidth = 56;

  // Major opcodes, bits 6..0 of the instruction word.
  localparam logic [6:0] OpcLoad   = 7'b0000011;
  localparam logic [6:0] OpcOpImm  = 7'b0010011;
  localparam logic [6:0] OpcAuipc  = 7'b0010111;
  localparam logic [6:0] OpcStore  = 7'b0100011;
  localparam logic [6:0] OpcOp     = 7'b0110011;
  localparam logic [6:0] OpcLui    = 7'b0110111;
  localparam logic [6:0] OpcBranch = 7'b1100011;
  localparam logic [6:0] OpcJalr   = 7'b1100111;
  localparam logic [6:0] OpcJal    = 7'b1101111;

  localparam logic [6:0] Funct7Base = 7'b0000000;
  localparam logic [6:0] Funct7Alt  = 7'b0100000;

  typedef enum logic [2:0] {
    FMT_R = 3'd0,
    FMT_I = 3'd1,
    FMT_S = 3'd2,
    FMT_B = 3'd3,
    FMT_U = 3'd4,
    FMT_J = 3'd5
  } format_e;

  typedef enum logic [5:0] {
    OP_LUI   = 6'd0,
    OP_AUIPC = 6'd1,
    OP_JAL   = 6'd2,
    OP_JALR  = 6'd3,
    OP_BEQ   = 6'd4,
    OP_BNE   = 6'd5,
    OP_BLT   = 6'd6,
    OP_BGE   = 6'd7,
    OP_BLTU  = 6'd8,
    OP_BGEU  = 6'd9,
    OP_LB    = 6'd10,
    OP_LH    = 6'd11,
    OP_LW    = 6'd12,
    OP_LBU   = 6'd13,
    OP_LHU   = 6'd14,
    OP_SB    = 6'd15,
    OP_SH    = 6'd16,
    OP_SW    = 6'd17,
    OP_ADDI  = 6'd18,
    OP_SLTI  = 6'd19,
    OP_SLTIU = 6'd20,
    OP_XORI  = 6'd21,
    OP_ORI   = 6'd22,
    OP_ANDI  = 6'd23,
    OP_SLLI  = 6'd24,
    OP_SRLI  = 6'd25,
    OP_SRAI  = 6'd26,
    OP_ADD   = 6'd27,
    OP_SUB   = 6'd28,
    OP_SLL   = 6'd29,
    OP_SLT   = 6'd30,
    OP_SLTU  = 6'd31,
    OP_XOR   = 6'd32,
    OP_SRL   = 6'd33,
    OP_SRA   = 6'd34,
    OP_OR    = 6'd35,
    OP_AND   = 6'd36,
    OP_NONE  = 6'd37
  } op_e;

  typedef struct packed {
    logic                       illegal;
    format_e                    format;
    op_e                        operation;
    logic [RegWidth-1:0]        dest_reg;
    logic [RegWidth-1:0]        src1_reg;
    logic [RegWidth-1:0]        src2_reg;
    logic signed [ImmWidth-1:0] immediate;
  } decoded_t;

endpackage

>>> hw/rtl/rv32i_instruction_decoder_top.sv
// Top level of the RV32I instruction decoder: input register, decode logic, result register.
// Depends on rv32i_dec_pkg.

// The block takes one 32-bit RV32I instruction word per item and returns one decoded
// item for it: format, operation code, the register numbers rd, rs1 and rs2 (zero where
// the format has none) and the immediate, sign-extended per format, or the unsigned shift
// amount for SLLI, SRLI and SRAI. An unknown major opcode sets the illegal flag on tuser
// and clears every other field, with the operation set to the "none" code; a known opcode
// with an unlisted funct3 or funct7 combination is decoded normally but carries the "none"
// code. The block has two register stages, the captured instruction word and the decoded
// result. An accepted item is captured in the instruction register, and its decoded result
// is then loaded into the result register and driven on the output. One item is taken per
// clock when the downstream side keeps tready high; the rate is set only by the output
// handshake, since the decode itself is a single pass of bit slicing and opcode compares
// between the two registers. The input tready follows the output side combinationally, so
// a held result stalls the input only once both stages are full.
module rv32i_instruction_decoder_top
  import rv32i_dec_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0 up: instr_word[31:0].
  input  logic [InstrWidth-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0 up: format[2:0], operation[8:3], dest_reg[13:9], src1_reg[18:14],
  // src2_reg[23:19], immediate[55:24].
  output logic [TdataWidth-1:0] m_axis_tdata,
  // Fields from bit 0 up: illegal[0].
  output logic                  m_axis_tuser
);

  logic                  in_valid_q;
  logic [InstrWidth-1:0] instr_q;
  logic                  out_valid_q;
  decoded_t              result_q;
  decoded_t              result_d;
  logic                  out_advance;
  logic                  in_advance;

  // The result stage moves when it is empty or its item is being taken, and the input
  // stage moves when the result stage can take what it holds.
  assign out_advance   = !out_valid_q || m_axis_tready;
  assign in_advance    = !in_valid_q || out_advance;
  assign s_axis_tready = in_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_advance) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_advance && s_axis_tvalid) begin
      instr_q <= s_axis_tdata;
    end
    if (out_advance && in_valid_q) begin
      result_q <= result_d;
    end
  end

  // Instruction fields.
  logic [6:0]          opc;
  logic [2:0]          f3;
  logic [6:0]          f7;
  logic [RegWidth-1:0] rd;
  logic [RegWidth-1:0] rs1;
  logic [RegWidth-1:0] rs2;
  logic [ImmWidth-1:0] imm_i;
  logic [ImmWidth-1:0] imm_s;
  logic [ImmWidth-1:0] imm_b;
  logic [ImmWidth-1:0] imm_u;
  logic [ImmWidth-1:0] imm_j;
  logic [ImmWidth-1:0] imm_shamt;

  assign opc = instr_q[6:0];
  assign rd  = instr_q[11:7];
  assign f3  = instr_q[14:12];
  assign rs1 = instr_q[19:15];
  assign rs2 = instr_q[24:20];
  assign f7  = instr_q[31:25];

  assign imm_i     = {{20{instr_q[31]}}, instr_q[31:20]};
  assign imm_s     = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
  assign imm_b     = {{19{instr_q[31]}}, instr_q[31], instr_q[7], instr_q[30:25],
                      instr_q[11:8], 1'b0};
  assign imm_u     = {instr_q[31:12], 12'b0};
  assign imm_j     = {{11{instr_q[31]}}, instr_q[31], instr_q[19:12], instr_q[20],
                      instr_q[30:21], 1'b0};
  assign imm_shamt = {27'b0, rs2};

  always_comb begin
    result_d = '{illegal:   1'b0,
                 format:    FMT_R,
                 operation: OP_NONE,
                 dest_reg:  '0,
                 src1_reg:  '0,
                 src2_reg:  '0,
                 immediate: '0};
    unique case (opc)
      OpcLui, OpcAuipc: begin
        result_d.format    = FMT_U;
        result_d.dest_reg  = rd;
        result_d.immediate = imm_u;
        result_d.operation = (opc == OpcLui) ? OP_LUI : OP_AUIPC;
      end
      OpcJal: begin
        result_d.format    = FMT_J;
        result_d.dest_reg  = rd;
        result_d.immediate = imm_j;
        result_d.operation = OP_JAL;
      end
      OpcJalr: begin
        result_d.format    = FMT_I;
        result_d.dest_reg  = rd;
        result_d.src1_reg  = rs1;
        result_d.immediate = imm_i;
        result_d.operation = (f3 == 3'd0) ? OP_JALR : OP_NONE;
      end
      OpcLoad: begin
        result_d.format    = FMT_I;
        result_d.dest_reg  = rd;
        result_d.src1_reg  = rs1;
        result_d.immediate = imm_i;
        unique case (f3)
          3'd0:    result_d.operation = OP_LB;
          3'd1:    result_d.operation = OP_LH;
          3'd2:    result_d.operation = OP_LW;
          3'd4:    result_d.operation = OP_LBU;
          3'd5:    result_d.operation = OP_LHU;
          default: result_d.operation = OP_NONE;
        endcase
      end
      OpcOpImm: begin
        result_d.format   = FMT_I;
        result_d.dest_reg = rd;
        result_d.src1_reg = rs1;
        // Shift immediates carry the plain shift amount whatever funct7 holds.
        result_d.immediate = (f3 == 3'd1 || f3 == 3'd5) ? imm_shamt : imm_i;
        unique case (f3)
          3'd0: result_d.operation = OP_ADDI;
          3'd1: result_d.operation = (f7 == Funct7Base) ? OP_SLLI : OP_NONE;
          3'd2: result_d.operation = OP_SLTI;
          3'd3: result_d.operation = OP_SLTIU;
          3'd4: result_d.operation = OP_XORI;
          3'd5: begin
            if (f7 == Funct7Base) begin
              result_d.operation = OP_SRLI;
            end else if (f7 == Funct7Alt) begin
              result_d.operation = OP_SRAI;
            end else begin
              result_d.operation = OP_NONE;
            end
          end
          3'd6: result_d.operation = OP_ORI;
          3'd7: result_d.operation = OP_ANDI;
          default: result_d.operation = OP_NONE;
        endcase
      end
      OpcStore: begin
        result_d.format    = FMT_S;
        result_d.src1_reg  = rs1;
        result_d.src2_reg  = rs2;
        result_d.immediate = imm_s;
        unique case (f3)
          3'd0:    result_d.operation = OP_SB;
          3'd1:    result_d.operation = OP_SH;
          3'd2:    result_d.operation = OP_SW;
          default: result_d.operation = OP_NONE;
        endcase
      end
      OpcBranch: begin
        result_d.format    = FMT_B;
        result_d.src1_reg  = rs1;
        result_d.src2_reg  = rs2;
        result_d.immediate = imm_b;
        unique case (f3)
          3'd0:    result_d.operation = OP_BEQ;
          3'd1:    result_d.operation = OP_BNE;
          3'd4:    result_d.operation = OP_BLT;
          3'd5:    result_d.operation = OP_BGE;
          3'd6:    result_d.operation = OP_BLTU;
          3'd7:    result_d.operation = OP_BGEU;
          default: result_d.operation = OP_NONE;
        endcase
      end
      OpcOp: begin
        // R format has no immediate, so it stays zero.
        result_d.format   = FMT_R;
        result_d.dest_reg = rd;
        result_d.src1_reg = rs1;
        result_d.src2_reg = rs2;
        if (f7 == Funct7Base) begin
          unique case (f3)
            3'd0: result_d.operation = OP_ADD;
            3'd1: result_d.operation = OP_SLL;
            3'd2: result_d.operation = OP_SLT;
            3'd3: result_d.operation = OP_SLTU;
            3'd4: result_d.operation = OP_XOR;
            3'd5: result_d.operation = OP_SRL;
            3'd6: result_d.operation = OP_OR;
            3'd7: result_d.operation = OP_AND;
            default: result_d.operation = OP_NONE;
          endcase
        end else if (f7 == Funct7Alt && f3 == 3'd0) begin
          result_d.operation = OP_SUB;
        end else if (f7 == Funct7Alt && f3 == 3'd5) begin
          result_d.operation = OP_SRA;
        end else begin
          result_d.operation = OP_NONE;
        end
      end
      default: begin
        result_d.illegal = 1'b1;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = result_q.illegal;
  assign m_axis_tdata  = {result_q.immediate, result_q.src2_reg, result_q.src1_reg,
                          result_q.dest_reg, result_q.operation, result_q.format};

endmodule

>>> tb/rv32i_decode_checker.sv
// Checker for the RV32I instruction decoder: watches both stream channels, decodes each
// accepted instruction word on its own and compares every decoded item field by field.
// Depends on rv32i_dec_pkg.
module rv32i_decode_checker
  import rv32i_dec_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [InstrWidth-1:0] in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [TdataWidth-1:0] out_data_i,
  input  logic                  out_flag_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  decoded_t decodes_due[$];
  logic [InstrWidth-1:0] words_due[$];
  int errors = 0;

  assign fail_count_o = errors;

  // Expected decode of one instruction word.
  function automatic decoded_t decode_instr(logic [InstrWidth-1:0] w);
    decoded_t d;
    logic [2:0] f3;
    logic [6:0] f7;
    logic signed [ImmWidth-1:0] imm_i;
    f3 = w[14:12];
    f7 = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    d.illegal   = 1'b0;
    d.format    = FMT_R;
    d.operation = OP_NONE;
    d.dest_reg  = '0;
    d.src1_reg  = '0;
    d.src2_reg  = '0;
    d.immediate = '0;
    case (w[6:0])
      OpcLui, OpcAuipc: begin
        d.format    = FMT_U;
        d.dest_reg  = w[11:7];
        d.immediate = {w[31:12], 12'b0};
        if (w[6:0] == OpcLui) d.operation = OP_LUI;
        else d.operation = OP_AUIPC;
      end
      OpcJal: begin
        d.format    = FMT_J;
        d.dest_reg  = w[11:7];
        d.operation = OP_JAL;
        d.immediate = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      end
      OpcJalr: begin
        d.format    = FMT_I;
        d.dest_reg  = w[11:7];
        d.src1_reg  = w[19:15];
        d.immediate = imm_i;
        if (f3 == 3'b000) d.operation = OP_JALR;
      end
      OpcLoad: begin
        d.format    = FMT_I;
        d.dest_reg  = w[11:7];
        d.src1_reg  = w[19:15];
        d.immediate = imm_i;
        case (f3)
          3'b000: d.operation = OP_LB;
          3'b001: d.operation = OP_LH;
          3'b010: d.operation = OP_LW;
          3'b100: d.operation = OP_LBU;
          3'b101: d.operation = OP_LHU;
          default: d.operation = OP_NONE;
        endcase
      end
      OpcOpImm: begin
        d.format   = FMT_I;
        d.dest_reg = w[11:7];
        d.src1_reg = w[19:15];
        // Shifts carry an unsigned shift amount, whatever the upper bits hold.
        if (f3 == 3'b001 || f3 == 3'b101) d.immediate = {27'b0, w[24:20]};
        else d.immediate = imm_i;
        case (f3)
          3'b000: d.operation = OP_ADDI;
          3'b001: if (f7 == Funct7Base) d.operation = OP_SLLI;
          3'b010: d.operation = OP_SLTI;
          3'b011: d.operation = OP_SLTIU;
          3'b100: d.operation = OP_XORI;
          3'b101: begin
            if (f7 == Funct7Base) d.operation = OP_SRLI;
            else if (f7 == Funct7Alt) d.operation = OP_SRAI;
          end
          3'b110: d.operation = OP_ORI;
          default: d.operation = OP_ANDI;
        endcase
      end
      OpcStore: begin
        d.format    = FMT_S;
        d.src1_reg  = w[19:15];
        d.src2_reg  = w[24:20];
        d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
        case (f3)
          3'b000: d.operation = OP_SB;
          3'b001: d.operation = OP_SH;
          3'b010: d.operation = OP_SW;
          default: d.operation = OP_NONE;
        endcase
      end
      OpcBranch: begin
        d.format    = FMT_B;
        d.src1_reg  = w[19:15];
        d.src2_reg  = w[24:20];
        d.immediate = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          3'b000: d.operation = OP_BEQ;
          3'b001: d.operation = OP_BNE;
          3'b100: d.operation = OP_BLT;
          3'b101: d.operation = OP_BGE;
          3'b110: d.operation = OP_BLTU;
          3'b111: d.operation = OP_BGEU;
          default: d.operation = OP_NONE;
        endcase
      end
      OpcOp: begin
        d.format   = FMT_R;
        d.dest_reg = w[11:7];
        d.src1_reg = w[19:15];
        d.src2_reg = w[24:20];
        if (f7 == Funct7Base) begin
          case (f3)
            3'b000: d.operation = OP_ADD;
            3'b001: d.operation = OP_SLL;
            3'b010: d.operation = OP_SLT;
            3'b011: d.operation = OP_SLTU;
            3'b100: d.operation = OP_XOR;
            3'b101: d.operation = OP_SRL;
            3'b110: d.operation = OP_OR;
            default: d.operation = OP_AND;
          endcase
        end else if (f7 == Funct7Alt) begin
          if (f3 == 3'b000) d.operation = OP_SUB;
          else if (f3 == 3'b101) d.operation = OP_SRA;
        end
      end
      default: d.illegal = 1'b1;
    endcase
    return d;
  endfunction

  function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // The result side is compared before the new item is queued, since the block
  // never returns an item in the cycle it accepts it.
  always @(posedge clk_i) begin : watch
    decoded_t want;
    logic [InstrWidth-1:0] word;
    int bad;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (decodes_due.size() == 0) begin
          $display("%0t: decoded item with none expected, expected nothing, actual %0h/%0h",
                   $time, out_flag_i, out_data_i);
          errors++;
        end else begin
          want = decodes_due.pop_front();
          word = words_due.pop_front();
          bad = field_differs("illegal", want.illegal, out_flag_i)
              + field_differs("format", want.format, out_data_i[2:0])
              + field_differs("operation", want.operation, out_data_i[8:3])
              + field_differs("dest_reg", want.dest_reg, out_data_i[13:9])
              + field_differs("src1_reg", want.src1_reg, out_data_i[18:14])
              + field_differs("src2_reg", want.src2_reg, out_data_i[23:19])
              + field_differs("immediate", want.immediate, out_data_i[55:24]);
          if (bad != 0) begin
            $display("%0t:   for instruction word %08h", $time, word);
            errors += bad;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        decodes_due.push_back(decode_instr(in_word_i));
        words_due.push_back(in_word_i);
      end
      pending_o <= decodes_due.size();
    end else begin
      pending_o <= 0;
    end
  end

endmodule

>>> tb/tb.sv
// Testbench top for the RV32I instruction decoder: clock, reset, instruction stimulus and
// the output handshake, with the verdict. Depends on rv32i_dec_pkg, the decoder top level
// and rv32i_decode_checker, which does all prediction and comparison.
module tb;
  import rv32i_dec_pkg::*;

  // The limit is far above any correct run, so this only catches a block that hangs.
  localparam int CycleLimit   = 200000;
  localparam int HoldCycles   = 80;
  localparam int PhaseItems   = 310;
  localparam int NumPhases    = 4;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InstrWidth-1:0] s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TdataWidth-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  int fail_count;
  int pending;
  int cycle_count = 0;

  // Idle and stall odds, in percent, for the phase under way.
  int idle_pct = 0;
  int stall_pct = 0;

  // Raised by the stimulus, lowered by the receiver once its long hold-off is over.
  bit hold_req = 1'b0;

  rv32i_instruction_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  rv32i_decode_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_word_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_flag_i   (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run is cut off here if the stimulus or a drain never completes.
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Receiver: tready changes only at the falling edge. A hold-off request keeps it low
  // for a long stretch so that both register stages fill and the input stalls.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Packs the instruction fields from the top bits down, as the ISA lays them out.
  function automatic logic [31:0] enc(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                      logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  // Mostly well-formed words with a known major opcode and funct7 biased toward the two
  // legal values, so that every operation turns up often; the rest is raw noise, which
  // mostly lands on unknown opcodes.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [6:0] opc;
    int pick;
    w = $urandom;
    if ($urandom_range(99) < 15) return w;
    case ($urandom_range(8))
      0: opc = OpcLoad;
      1: opc = OpcOpImm;
      2: opc = OpcAuipc;
      3: opc = OpcStore;
      4: opc = OpcOp;
      5: opc = OpcLui;
      6: opc = OpcBranch;
      7: opc = OpcJalr;
      default: opc = OpcJal;
    endcase
    w[6:0] = opc;
    pick = $urandom_range(99);
    if (pick < 45) w[31:25] = Funct7Base;
    else if (pick < 80) w[31:25] = Funct7Alt;
    return w;
  endfunction

  // Offers one item and returns once it is accepted. An idle gap drops tvalid at the
  // falling edge; otherwise tvalid stays high from the previous item without a dip.
  task automatic send_word(input logic [31:0] w);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
  endtask

  // Waits until the checker holds no expectation, then idles for a random stretch.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat ($urandom_range(3, 12)) @(posedge clk_i);
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items: illegal opcodes, the extremes of every immediate format, and the
    // funct3 and funct7 combinations that fall back to the "none" operation.
    send_word(32'h0000_0000);
    send_word(32'hffff_ffff);
    send_word(32'h0000_007b);
    send_word(enc(7'h7f, 5'h1f, 5'h1f, 3'h7, 5'd31, OpcLui));
    send_word(enc(7'h00, 5'h00, 5'h00, 3'h0, 5'd0, OpcAuipc));
    send_word(enc(7'h40, 5'h00, 5'h00, 3'h0, 5'd1, OpcJal));
    send_word(enc(7'h3f, 5'h1f, 5'h1f, 3'h7, 5'd31, OpcJal));
    send_word(enc(7'h7f, 5'h1f, 5'd31, 3'h0, 5'd31, OpcJalr));
    send_word(enc(7'h01, 5'h02, 5'd3, 3'h3, 5'd4, OpcJalr));
    send_word(enc(7'h40, 5'h00, 5'd5, 3'h2, 5'd7, OpcLoad));
    send_word(enc(7'h12, 5'h03, 5'd6, 3'h3, 5'd8, OpcLoad));
    send_word(enc(7'h3f, 5'd9, 5'd10, 3'h2, 5'h1f, OpcStore));
    send_word(enc(7'h55, 5'd11, 5'd12, 3'h3, 5'h0a, OpcStore));
    send_word(enc(7'h40, 5'd31, 5'd31, 3'h0, 5'h00, OpcBranch));
    send_word(enc(7'h3f, 5'd0, 5'd0, 3'h7, 5'h1f, OpcBranch));
    send_word(enc(7'h2a, 5'd13, 5'd14, 3'h2, 5'h15, OpcBranch));
    send_word(enc(7'h3f, 5'h1f, 5'd1, 3'h0, 5'd2, OpcOpImm));
    send_word(enc(Funct7Base, 5'h1f, 5'd3, 3'h1, 5'd4, OpcOpImm));
    send_word(enc(7'h01, 5'h10, 5'd5, 3'h1, 5'd6, OpcOpImm));
    send_word(enc(Funct7Alt, 5'h1f, 5'd7, 3'h5, 5'd8, OpcOpImm));
    send_word(enc(7'h7f, 5'h1f, 5'd9, 3'h5, 5'd10, OpcOpImm));
    send_word(enc(Funct7Base, 5'd31, 5'd31, 3'h0, 5'd31, OpcOp));
    send_word(enc(Funct7Alt, 5'd1, 5'd2, 3'h0, 5'd3, OpcOp));
    send_word(enc(Funct7Alt, 5'd4, 5'd5, 3'h5, 5'd6, OpcOp));
    send_word(enc(Funct7Alt, 5'd7, 5'd8, 3'h1, 5'd9, OpcOp));
    send_word(enc(7'h7f, 5'd10, 5'd11, 3'h7, 5'd12, OpcOp));
    drain();

    // Random phases: none idle, sender idle, receiver stalling, then both. The first
    // phase also carries the long receiver hold-off while the sender keeps offering.
    // Every phase ends with the sender paused until every decoded item is back.
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 0 && n == PhaseItems / 2) hold_req = 1'b1;
        send_word(random_word());
      end
      drain();
    end

    // Let any stray item show up before the verdict.
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
